>>> rtl/core/chunk_frustum_cull_macros.svh
// Assertion macros shared by the chunk frustum cull RTL.
`ifndef CHUNK_FRUSTUM_CULL_MACROS_SVH
`define CHUNK_FRUSTUM_CULL_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define CFC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, active during reset as well
`define CFC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> rtl/core/cfc_pkg.sv
// Shared types and constants for the chunk frustum cull block.
package cfc_pkg;

    localparam int CFC_EDGE_DEF = 32;
    localparam int NUM_PLANES   = 6;
    localparam int ORTHO_PLANES = 4;
    localparam int BOX_PAD      = 1;

    // Coefficient and coordinate widths
    localparam int COEF_W = 16;
    localparam int XW     = 26;            // covers index * 256 + 256
    localparam int YW     = 8;
    localparam int PW     = COEF_W + XW;   // one product term
    localparam int SW     = PW + 2;        // sum of four terms

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORTHO = 3'd6;

    // Plane register layout: a in 15:0 up to d in 63:48
    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } t_plane;

    // Corner coordinates of one request, with its valid bit
    typedef struct packed {
        logic                 valid;
        logic                 ortho;
        logic signed [XW-1:0] x0;
        logic signed [XW-1:0] x1;
        logic signed [XW-1:0] z0;
        logic signed [XW-1:0] z1;
        logic [YW-1:0]        y0;
        logic [YW-1:0]        y1;
    } t_corner;

endpackage

>>> rtl/core/cfc_corner.sv
// Corner stage: builds padded box extents of one chunk column request.
module cfc_corner #(
    parameter int CHUNK_EDGE = cfc_pkg::CFC_EDGE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_ortho,
    input  logic signed [15:0]    i_chunk_x,
    input  logic signed [15:0]    i_chunk_z,
    input  logic [cfc_pkg::YW-1:0] i_bottom_y,
    input  logic [cfc_pkg::YW-1:0] i_top_y,
    output cfc_pkg::t_corner      o_corner
);
    import cfc_pkg::*;

    localparam logic signed [XW-1:0] EDGE_S = XW'(CHUNK_EDGE);
    localparam logic signed [XW-1:0] PAD_S  = XW'(BOX_PAD);

    logic signed [XW-1:0] w_cx;
    logic signed [XW-1:0] w_cz;
    logic signed [XW-1:0] w_bx;
    logic signed [XW-1:0] w_bz;
    t_corner              r_corner;
    t_corner              n_corner;

    // Base corner is index * edge; pad one unit on each side
    always_comb begin
        w_cx = XW'(i_chunk_x);
        w_cz = XW'(i_chunk_z);
        w_bx = w_cx * EDGE_S;
        w_bz = w_cz * EDGE_S;
        n_corner.valid = i_accept;
        n_corner.ortho = i_ortho;
        n_corner.x0    = w_bx - PAD_S;
        n_corner.x1    = w_bx + EDGE_S;
        n_corner.z0    = w_bz - PAD_S;
        n_corner.z1    = w_bz + EDGE_S;
        n_corner.y0    = i_bottom_y;
        n_corner.y1    = i_top_y;
    end

    // Valid bit is reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner.valid <= 1'b0;
        end else begin
            r_corner.valid <= n_corner.valid;
        end
        r_corner.ortho <= n_corner.ortho;
        r_corner.x0    <= n_corner.x0;
        r_corner.x1    <= n_corner.x1;
        r_corner.z0    <= n_corner.z0;
        r_corner.z1    <= n_corner.z1;
        r_corner.y0    <= n_corner.y0;
        r_corner.y1    <= n_corner.y1;
    end

    assign o_corner = r_corner;

endmodule

>>> rtl/core/cfc_plane_eval.sv
// Plane unit: three-stage test of eight box corners against one plane.
module cfc_plane_eval (
    input  logic             i_clk,
    input  cfc_pkg::t_corner i_corner,
    input  cfc_pkg::t_plane  i_plane,
    output logic             o_any_in
);
    import cfc_pkg::*;

    logic signed [PW-1:0] r_ax [2];
    logic signed [PW-1:0] r_cz [2];
    logic signed [PW-1:0] r_by [2];
    logic signed [PW-1:0] r_d;
    logic signed [SW-1:0] r_xz [4];
    logic signed [SW-1:0] r_yd [2];
    logic                 r_any_in;
    logic                 n_any_in;
    logic signed [SW-1:0] w_sum;

    // Stage A: one multiplier per term
    always_ff @(posedge i_clk) begin
        r_ax[0] <= PW'(i_plane.a) * PW'(i_corner.x0);
        r_ax[1] <= PW'(i_plane.a) * PW'(i_corner.x1);
        r_cz[0] <= PW'(i_plane.c) * PW'(i_corner.z0);
        r_cz[1] <= PW'(i_plane.c) * PW'(i_corner.z1);
        r_by[0] <= PW'(i_plane.b) * PW'($signed({1'b0, i_corner.y0}));
        r_by[1] <= PW'(i_plane.b) * PW'($signed({1'b0, i_corner.y1}));
        r_d     <= PW'(i_plane.d);
    end

    // Stage B: partial sums in x-z and y-d
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_xz[j] <= SW'(r_ax[j % 2]) + SW'(r_cz[j / 2]);
        end
        for (int k = 0; k < 2; k++) begin
            r_yd[k] <= SW'(r_by[k]) + SW'(r_d);
        end
    end

    // Stage C: a corner is inside when its sum is not negative
    always_comb begin
        n_any_in = 1'b0;
        w_sum    = '0;
        for (int j = 0; j < 8; j++) begin
            w_sum    = r_xz[j % 4] + r_yd[j / 4];
            n_any_in = n_any_in | ~w_sum[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_any_in <= n_any_in;
    end

    assign o_any_in = r_any_in;

endmodule

>>> rtl/core/chunk_frustum_cull.sv
// Top level of the chunk frustum cull block: config, pipeline and result.
// A request passes the corner register, plane stages A to C and the result register.
// Throughput: one request per cycle; six plane units run side by side,
// so o_busy stays low and the receiver cannot stall the pipeline.
// Reset (synchronous, active low) zeroes all planes and ortho_mode, which
// makes every box visible, and clears the valid bits of all stages.
`include "chunk_frustum_cull_macros.svh"

module chunk_frustum_cull #(
    parameter int CHUNK_EDGE = cfc_pkg::CFC_EDGE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [15:0]              i_chunk_x,
    input  logic signed [15:0]              i_chunk_z,
    input  logic [cfc_pkg::YW-1:0]          i_bottom_y,
    input  logic [cfc_pkg::YW-1:0]          i_top_y,
    output logic                            o_valid,
    output logic                            o_visible,
    input  logic                            i_cfg_we,
    input  cfc_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cfc_pkg::*;

    localparam int LAT = 5;

    t_plane            r_plane [NUM_PLANES];
    logic              r_ortho;
    t_corner           w_corner;
    logic [NUM_PLANES-1:0] w_any;
    logic [2:0]        r_vld_d;
    logic [2:0]        r_ortho_d;
    logic              r_out_vld;
    logic              r_visible;
    logic              n_visible;
    logic              w_accept;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
            r_ortho <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ORTHO) begin
                r_ortho <= i_cfg_data[0];
            end else begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    if (i_cfg_idx == t_cfg_idx'(p)) begin
                        r_plane[p] <= t_plane'(i_cfg_data);
                    end
                end
            end
        end
    end

    // Corner stage
    cfc_corner #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_corner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_ortho    (r_ortho),
        .i_chunk_x  (i_chunk_x),
        .i_chunk_z  (i_chunk_z),
        .i_bottom_y (i_bottom_y),
        .i_top_y    (i_top_y),
        .o_corner   (w_corner)
    );

    // One plane unit per plane
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        cfc_plane_eval u_plane (
            .i_clk    (i_clk),
            .i_corner (w_corner),
            .i_plane  (r_plane[g]),
            .o_any_in (w_any[g])
        );
    end

    // Valid and mode travel alongside the plane units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld_d   <= {r_vld_d[1:0], w_corner.valid};
            r_out_vld <= r_vld_d[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ortho_d <= {r_ortho_d[1:0], w_corner.ortho};
    end

    // Visible unless some active plane has no corner inside
    always_comb begin
        n_visible = &w_any[ORTHO_PLANES-1:0];
        if (!r_ortho_d[2]) begin
            n_visible = n_visible & (&w_any[NUM_PLANES-1:ORTHO_PLANES]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_visible <= n_visible;
    end

    assign o_valid   = r_out_vld;
    assign o_visible = r_visible;

    // Checks
    `CFC_ASSERT_IMPL(a_strobe_lat, i_clk, i_rst_n, o_valid, $past(w_accept, LAT))
    `CFC_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_valid)
    `CFC_ASSERT_IMPL(a_ortho_four, i_clk, i_rst_n, o_valid && $past(r_ortho_d[2]),
                     o_visible == $past(&w_any[ORTHO_PLANES-1:0]))

endmodule

>>> dv/chunk_frustum_cull_tb.sv
// Self-checking testbench for the chunk frustum cull block, directed and random requests.
`timescale 1ns / 1ps

module chunk_frustum_cull_tb;
    import cfc_pkg::*;

    localparam int       EDGE         = CFC_EDGE_DEF;
    localparam t_cfg_idx CFG_NONE     = 3'd7;   // decodes to no register
    localparam int       DRAIN_CYCLES = 8;      // pipeline depth is five
    localparam int       ITEMS_PHASE  = 200;
    localparam int       SETTING_LEN  = 50;     // requests per random plane set

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic signed [15:0]    i_chunk_x;
    logic signed [15:0]    i_chunk_z;
    logic [YW-1:0]         i_bottom_y;
    logic [YW-1:0]         i_top_y;
    logic                  o_valid;
    logic                  o_visible;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow of the plane registers and the view mode
    t_plane plane_cfg [NUM_PLANES];
    logic   ortho_cfg;

    logic exp_visible_q [$];
    int   n_mismatch;
    int   n_checked;
    int   n_visible;
    int   n_culled;
    int   n_settings;

    chunk_frustum_cull #(
        .CHUNK_EDGE (EDGE)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_chunk_x  (i_chunk_x),
        .i_chunk_z  (i_chunk_z),
        .i_bottom_y (i_bottom_y),
        .i_top_y    (i_top_y),
        .o_valid    (o_valid),
        .o_visible  (o_visible),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Box vs. active planes: culled once a plane has all eight corners below zero
    function automatic logic cull_visible(input logic signed [15:0] cx, cz,
                                          input logic [7:0] ylo, yhi);
        longint xs [2];
        longint ys [2];
        longint zs [2];
        longint s;
        int     n_planes;
        logic   any_in;
        t_plane pl;
        xs[0] = longint'(cx) * EDGE - BOX_PAD;
        xs[1] = xs[0] + EDGE + BOX_PAD;
        zs[0] = longint'(cz) * EDGE - BOX_PAD;
        zs[1] = zs[0] + EDGE + BOX_PAD;
        ys[0] = longint'(ylo);
        ys[1] = longint'(yhi);
        n_planes = ortho_cfg ? ORTHO_PLANES : NUM_PLANES;
        for (int p = 0; p < n_planes; p++) begin
            pl = plane_cfg[p];
            any_in = 1'b0;
            for (int ix = 0; ix < 2; ix++)
                for (int iy = 0; iy < 2; iy++)
                    for (int iz = 0; iz < 2; iz++) begin
                        s = longint'(pl.a) * xs[ix] + longint'(pl.b) * ys[iy]
                          + longint'(pl.c) * zs[iz] + longint'(pl.d);
                        if (s >= 0)
                            any_in = 1'b1;
                    end
            if (!any_in)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] mk_plane(input logic signed [15:0] a, b, c, d);
        t_plane pl;
        pl.a = a;
        pl.b = b;
        pl.c = c;
        pl.d = d;
        return pl;
    endfunction

    // Mix of never-culling, arbitrary and near-origin planes
    function automatic logic [63:0] rand_plane();
        t_plane pl;
        case ($urandom_range(3))
            0: begin
                return '0;
            end
            1: begin
                return {$urandom, $urandom};
            end
            default: begin
                pl.a = 16'($urandom_range(512) - 256);
                pl.b = 16'($urandom_range(512) - 256);
                pl.c = 16'($urandom_range(512) - 256);
                pl.d = 16'($urandom);
                return pl;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        n_mismatch++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // One request; the expected result is queued when the block takes it
    task automatic send_req(input logic signed [15:0] cx, cz, input logic [7:0] ylo, yhi);
        i_start    <= 1'b1;
        i_chunk_x  <= cx;
        i_chunk_z  <= cz;
        i_bottom_y <= ylo;
        i_top_y    <= yhi;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        exp_visible_q.push_back(cull_visible(cx, cz, ylo, yhi));
    endtask

    // Gap cycle with junk on the payload
    task automatic idle_cycle();
        i_start    <= 1'b0;
        i_chunk_x  <= 16'($urandom);
        i_chunk_z  <= 16'($urandom);
        i_bottom_y <= 8'($urandom);
        i_top_y    <= 8'($urandom);
        @(posedge i_clk);
    endtask

    // Hold off until every pending result has come back and the pipe is empty
    task automatic drain();
        i_start <= 1'b0;
        while (exp_visible_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx < NUM_PLANES)
            plane_cfg[idx] = data;
        else if (idx == CFG_ORTHO)
            ortho_cfg = data[0];
        @(posedge i_clk);
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
        n_settings++;
        @(posedge i_clk);
    endtask

    task automatic clear_planes();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(t_cfg_idx'(p), '0);
    endtask

    // Zero planes after reset: nothing may be culled
    task automatic test_reset_state();
        send_req(16'sd0, 16'sd0, 8'd0, 8'd255);
        send_req(-16'sd32768, 16'sd32767, 8'd255, 8'd0);
        send_req(16'sd32767, -16'sd32768, 8'd128, 8'd127);
    endtask

    // Corners landing exactly on a plane count as inside
    task automatic test_plane_bounds();
        drain();
        clear_planes();
        write_reg(CFG_ORTHO, 64'h0);
        write_reg(t_cfg_idx'(0), mk_plane(16'sd0, 16'sd256, 16'sd0, -16'sd2560)); // y >= 10
        cfg_close();
        send_req(16'sd0, 16'sd0, 8'd9, 8'd9);
        send_req(16'sd0, 16'sd0, 8'd9, 8'd10);
        send_req(16'sd0, 16'sd0, 8'd10, 8'd9);     // reversed height range
        send_req(16'sd5, -16'sd5, 8'd255, 8'd255);
        send_req(16'sd0, 16'sd0, 8'd0, 8'd0);
        drain();
        write_reg(t_cfg_idx'(0), mk_plane(16'sd256, 16'sd0, 16'sd0, 16'sd0));     // x >= 0
        cfg_close();
        send_req(-16'sd1, 16'sd0, 8'd0, 8'd0);
        send_req(-16'sd2, 16'sd0, 8'd0, 8'd0);
        send_req(-16'sd32768, 16'sd0, 8'd0, 8'd255);
        send_req(16'sd32767, 16'sd0, 8'd255, 8'd0);
        drain();
        write_reg(t_cfg_idx'(0), '0);
        write_reg(t_cfg_idx'(3), mk_plane(16'sd0, 16'sd0, -16'sd256, 16'sd0));    // z <= 0
        cfg_close();
        send_req(16'sd0, 16'sd0, 8'd0, 8'd0);
        send_req(16'sd0, 16'sd1, 8'd0, 8'd0);
        send_req(16'sd0, -16'sd32768, 8'd0, 8'd0);
    endtask

    // Largest positive and negative coefficients at the far corners
    task automatic test_coef_extremes();
        drain();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(t_cfg_idx'(p), 64'h7FFF_7FFF_7FFF_7FFF);
        cfg_close();
        send_req(16'sd32767, 16'sd32767, 8'd255, 8'd255);
        send_req(-16'sd32768, -16'sd32768, 8'd0, 8'd0);
        drain();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(t_cfg_idx'(p), 64'h8000_8000_8000_8000);
        cfg_close();
        send_req(16'sd32767, 16'sd32767, 8'd255, 8'd255);
        send_req(-16'sd32768, -16'sd32768, 8'd0, 8'd0);
    endtask

    // Plane 4 culls everything; only perspective mode should see it
    task automatic test_mode_select();
        drain();
        clear_planes();
        write_reg(t_cfg_idx'(4), mk_plane(16'sd0, 16'sd0, 16'sd0, -16'sd256));
        write_reg(CFG_ORTHO, 64'hFFFF_FFFF_FFFF_FFFE);   // only bit 0 counts
        cfg_close();
        send_req(16'sd3, 16'sd3, 8'd10, 8'd20);
        drain();
        write_reg(CFG_ORTHO, 64'h8000_0000_0000_0001);
        cfg_close();
        send_req(16'sd3, 16'sd3, 8'd10, 8'd20);
        drain();
        write_reg(CFG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);    // no register there
        cfg_close();
        send_req(-16'sd3, 16'sd7, 8'd200, 8'd20);
        drain();
        write_reg(CFG_ORTHO, 64'h2);
        cfg_close();
        send_req(-16'sd3, 16'sd7, 8'd200, 8'd20);
    endtask

    task automatic load_random_setting();
        drain();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(t_cfg_idx'(p), rand_plane());
        write_reg(CFG_ORTHO, {$urandom, $urandom});
        if ($urandom_range(3) == 0)
            write_reg(CFG_NONE, {$urandom, $urandom});
        cfg_close();
    endtask

    // Random requests, mostly near the origin where planes cut through boxes
    task automatic test_random_stream(input int n_items, input int idle_pct);
        logic signed [15:0] cx;
        logic signed [15:0] cz;
        for (int i = 0; i < n_items; i++) begin
            if (i % SETTING_LEN == 0)
                load_random_setting();
            while ($urandom_range(99) < idle_pct)
                idle_cycle();
            cx = ($urandom_range(3) != 0) ? 16'($urandom_range(16) - 8) : 16'($urandom);
            cz = ($urandom_range(3) != 0) ? 16'($urandom_range(16) - 8) : 16'($urandom);
            send_req(cx, cz, 8'($urandom), 8'($urandom));
        end
    endtask

    // Result checker: every strobe must match the oldest pending request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (exp_visible_q.size() == 0) begin
                flag_mismatch("result strobe with no request pending");
            end else begin
                logic exp_vis;
                exp_vis = exp_visible_q.pop_front();
                n_checked++;
                if (o_visible) n_visible++;
                else           n_culled++;
                if (o_visible !== exp_vis)
                    flag_mismatch($sformatf("visible: got %b, expected %b", o_visible, exp_vis));
            end
        end
    end

    // Main sequence
    initial begin
        i_clk      = 1'b0;
        n_mismatch = 0;
        n_checked  = 0;
        n_visible  = 0;
        n_culled   = 0;
        n_settings = 0;
        for (int p = 0; p < NUM_PLANES; p++)
            plane_cfg[p] = '0;
        ortho_cfg  = 1'b0;
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_chunk_x  <= '0;
        i_chunk_z  <= '0;
        i_bottom_y <= '0;
        i_top_y    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_plane_bounds();
        test_coef_extremes();
        test_mode_select();
        test_random_stream(ITEMS_PHASE, 9);
        test_random_stream(ITEMS_PHASE, 49);
        test_random_stream(ITEMS_PHASE, 0);
        drain();

        $display("Checked %0d cull requests over %0d plane settings (%0d visible, %0d culled),",
                 n_checked, n_settings, n_visible, n_culled);
        $display("including exact plane contact, extreme coefficients and both view modes.");
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
